[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search: shared definitions
// Sizes, register indexes, status codes and the result word type.
// ----------------------------------------------------------------------------
package mbps_pkg;

  // Window depth in bytes and width of a reported start offset.
  localparam int unsigned MAX_PATTERN = 16;
  localparam int unsigned OFFSET_BITS = 20;

  // Byte counter is one bit wider than an offset so that it can saturate.
  localparam int unsigned CNT_W = OFFSET_BITS + 1;
  // Width of an effective pattern length, 1 .. MAX_PATTERN.
  localparam int unsigned EFF_W = $clog2(MAX_PATTERN + 1);
  // Width of an index into the pattern and mask byte arrays.
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned REG_W  = 3;

  typedef enum logic [REG_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_MASK_LOW     = 3'd2,
    REG_MASK_HIGH    = 3'd3,
    REG_PATTERN_LEN  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FIRST     = 2'd1,
    ST_NO_MATCH  = 2'd2,
    ST_EARLIER   = 2'd3
  } status_e;

  typedef struct packed {
    status_e                status;
    logic [OFFSET_BITS-1:0] offset;
    logic                   done;
  } result_t;

  // Byte j of a register pair; bytes beyond the pair read as zero.
  function automatic logic [7:0] reg_byte(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                                          int unsigned j);
    logic [7:0] b;
    b = 8'h00;
    if (j < 8) begin
      b = lo[8*j +: 8];
    end else if (j < 16) begin
      b = hi[8*(j-8) +: 8];
    end
    return b;
  endfunction

endpackage

[rtl/masked_byte_pattern_search_top.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search: top level
// Finds the first masked match of a configured byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// A buffer arrives one byte per input word on the valid/ready input channel,
// with last_byte_i set on its final byte. Every accepted word yields exactly
// one result word on the output channel: a status, the start offset of the
// first match and a flag that the buffer has closed. The user sets pattern,
// mask and length via the write port while no word is in flight; not enforced.
//
// Throughput is one word per clock cycle while the receiver keeps up. The
// result of a word is registered, in the output register or in the skid
// register. The compare for a word is done in the same cycle that shifts it
// into the row of window cells, so nothing waits on an earlier word.
//
// When the receiver stalls, one further word is taken into a skid register
// and then in_ready_o drops until the output drains; in_ready_o comes straight
// from a flop. After reset the window, byte count and match state are clear,
// the pattern length is one and pattern and mask are zero. The closing byte of
// a buffer clears the search state again for the next buffer.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbps_pkg::REG_W-1:0]       cfg_index_i,
  input  logic [mbps_pkg::DATA_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [mbps_pkg::OFFSET_BITS-1:0] match_offset_o,
  output logic                             buffer_done_o
);
  import mbps_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] pat_lo_q, pat_hi_q, mask_lo_q, mask_hi_q;
  logic [LEN_W-1:0]  len_q;

  // Search state besides the window.
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   found_q, found_d;
  logic [OFFSET_BITS-1:0] found_off_q, found_off_d;

  logic [EFF_W-1:0] len_eff;
  logic [CNT_W:0]   total;
  logic [CNT_W:0]   start;
  logic             len_ok;
  logic             start_ok;
  logic             hit;
  logic             accept;
  result_t          res;
  result_t          res_out;

  logic [7:0]             pat_arr  [MAX_PATTERN];
  logic [7:0]             mask_arr [MAX_PATTERN];
  logic [7:0]             win      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  assign accept = in_valid_i & in_ready_o;

  // Configuration writes; an index past the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      mask_lo_q <= '0;
      mask_hi_q <= '0;
      len_q     <= LEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PATTERN_LOW:  pat_lo_q  <= cfg_wdata_i;
        REG_PATTERN_HIGH: pat_hi_q  <= cfg_wdata_i;
        REG_MASK_LOW:     mask_lo_q <= cfg_wdata_i;
        REG_MASK_HIGH:    mask_hi_q <= cfg_wdata_i;
        REG_PATTERN_LEN:  len_q     <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A length of zero counts as one, and a length past the window as the full
  // window.
  always_comb begin
    if (len_q == '0) begin
      len_eff = EFF_W'(1);
    end else if (int'(len_q) > MAX_PATTERN) begin
      len_eff = EFF_W'(MAX_PATTERN);
    end else begin
      len_eff = EFF_W'(len_q);
    end
  end

  // Row of window cells. Cell k holds the byte k positions back from the
  // newest and is compared with pattern byte (length - 1 - k).
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [EFF_W-1:0] sel;
    logic             active;
    logic [7:0]       byte_in;

    assign pat_arr[k]  = reg_byte(pat_lo_q, pat_hi_q, k);
    assign mask_arr[k] = reg_byte(mask_lo_q, mask_hi_q, k);
    assign active      = EFF_W'(k) < len_eff;
    assign sel         = len_eff - EFF_W'(k + 1);

    if (k == 0) begin : g_head
      assign byte_in = data_byte_i;
    end else begin : g_body
      assign byte_in = win[k-1];
    end

    mbps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (accept),
      .clear_i  (last_byte_i),
      .byte_i   (byte_in),
      .pat_i    (pat_arr[sel[IDX_W-1:0]]),
      .mask_i   (mask_arr[sel[IDX_W-1:0]]),
      .active_i (active),
      .byte_o   (win[k]),
      .hit_o    (cell_hit[k])
    );
  end

  // Byte count including this word, and the start offset a match would have.
  assign total    = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign len_ok   = total >= (CNT_W+1)'(len_eff);
  assign start    = total - (CNT_W+1)'(len_eff);
  assign start_ok = start[CNT_W:OFFSET_BITS] == '0;
  assign hit      = ~found_q & len_ok & start_ok & (&cell_hit);

  always_comb begin
    res.done   = last_byte_i;
    res.status = ST_SEARCHING;
    res.offset = '0;
    if (found_q) begin
      res.status = ST_EARLIER;
      res.offset = found_off_q;
    end else if (hit) begin
      res.status = ST_FIRST;
      res.offset = start[OFFSET_BITS-1:0];
    end else if (last_byte_i) begin
      res.status = ST_NO_MATCH;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    found_d     = found_q;
    found_off_d = found_off_q;
    if (accept) begin
      if (last_byte_i) begin
        cnt_d       = '0;
        found_d     = 1'b0;
        found_off_d = '0;
      end else begin
        if (!(&cnt_q)) begin
          cnt_d = total[CNT_W-1:0];
        end
        if (hit) begin
          found_d     = 1'b1;
          found_off_d = start[OFFSET_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      found_q     <= 1'b0;
      found_off_q <= '0;
    end else begin
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      found_off_q <= found_off_d;
    end
  end

  mbps_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .res_i   (res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign status_o       = res_out.status;
  assign match_offset_o = res_out.offset;
  assign buffer_done_o  = res_out.done;

  // A first match inside a buffer is remembered for the rest of it.
  a_hit_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hit && !last_byte_i) |=> found_q)
    else $error("first match not recorded");

  // The closing byte leaves the search state clear.
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> (cnt_q == '0 && !found_q && found_off_q == '0))
    else $error("search state not cleared after last byte");

  // Once a match is held, every later word reports it as an earlier match.
  a_earlier_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && found_q) |-> (res.status == ST_EARLIER && res.offset == found_off_q))
    else $error("held match not reported");

endmodule

[rtl/mbps_cell.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search: window cell
// Holds one byte of the search window and compares the byte it takes in.
// ----------------------------------------------------------------------------
module mbps_cell (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic [7:0] mask_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       hit_o
);
  import mbps_pkg::*;

  logic [7:0] byte_q, byte_d;

  // The compare looks at the byte this cell is about to hold.
  assign hit_o = ~active_i | ((byte_i & mask_i) == pat_i);

  always_comb begin
    byte_d = byte_q;
    if (load_i) begin
      byte_d = clear_i ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[rtl/mbps_out_buf.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search: output buffer
// Output register plus skid register, so the input side sees a registered ready.
// ----------------------------------------------------------------------------
module mbps_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mbps_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mbps_pkg::result_t res_o
);
  import mbps_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = out_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = res_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

[tb/sv/masked_byte_pattern_search_top_test.sv]
// ----------------------------------------------------------------------------
// Masked byte pattern search: self-checking testbench
// Streams byte buffers into the block, predicts each result word and checks it.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top_test;
  import mbps_pkg::*;

  // One byte of a buffer waiting to be offered, and whether the sender must
  // first wait for every outstanding result before offering it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;
  } scan_word_t;

  localparam int HOLD_CYCLES = 60;
  localparam logic [CNT_W:0] OFFSET_LIMIT = (CNT_W+1)'((1 << OFFSET_BITS) - 1);

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [REG_W-1:0]       cfg_index_i = '0;
  logic [DATA_W-1:0]      cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [7:0]             data_byte_i = '0;
  logic                   last_byte_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             status_o;
  logic [OFFSET_BITS-1:0] match_offset_o;
  logic                   buffer_done_o;

  masked_byte_pattern_search_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .match_offset_o (match_offset_o),
    .buffer_done_o  (buffer_done_o)
  );

  always #2 clk_i = ~clk_i;

  // Bytes still to be offered, and the result words the block owes us.
  scan_word_t bytes_to_send[$];
  result_t    search_results_due[$];

  // Our own copy of the configuration registers.
  logic [DATA_W-1:0] pat_lo, pat_hi, mask_lo, mask_hi;
  logic [LEN_W-1:0]  pat_len;

  // Our own copy of the search state.
  logic [7:0]             win [MAX_PATTERN];
  logic [CNT_W-1:0]       byte_count;
  bit                     found;
  logic [OFFSET_BITS-1:0] found_at;

  // Traffic shaping, set by the stimulus process between phases.
  bit sender_idle   = 1'b1;
  bit receiver_idle = 1'b1;
  bit hold_req      = 1'b0;

  int gap_left, stall_left, hold_left;
  int mismatches   = 0;
  int results_seen = 0;
  scan_word_t next_word;
  result_t    due;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // A length of zero behaves as one; anything beyond the window depth is
  // clipped to the full window.
  function automatic int eff_len();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return pat_len;
  endfunction

  function automatic void clear_search();
    for (int k = 0; k < MAX_PATTERN; k++) win[k] = 8'h00;
    byte_count = '0;
    found      = 1'b0;
    found_at   = '0;
  endfunction

  // Shifts one byte into the window and works out the result word it causes.
  // The window holds the newest byte in entry 0, so the candidate match starts
  // at entry n-1 and pattern byte j lines up with entry n-1-j.
  function automatic result_t search_step(input logic [7:0] b, input logic closing);
    result_t          r;
    int               n;
    logic [CNT_W:0]   total;
    logic [CNT_W:0]   start;
    logic [127:0]     pat;
    logic [127:0]     msk;
    bit               hit;
    n   = eff_len();
    pat = {pat_hi, pat_lo};
    msk = {mask_hi, mask_lo};
    for (int k = MAX_PATTERN - 1; k > 0; k--) win[k] = win[k-1];
    win[0] = b;
    total = {1'b0, byte_count} + 1'b1;
    // The byte count saturates rather than wrapping.
    if (byte_count != {CNT_W{1'b1}}) byte_count = total[CNT_W-1:0];
    r.status = ST_SEARCHING;
    r.offset = '0;
    r.done   = closing;
    if (found) begin
      r.status = ST_EARLIER;
      r.offset = found_at;
    end else begin
      hit = 1'b0;
      // A start offset that does not fit the offset field is never reported.
      if (total >= n) begin
        start = total - (CNT_W+1)'(n);
        if (start <= OFFSET_LIMIT) begin
          hit = 1'b1;
          for (int j = 0; j < n; j++) begin
            if ((win[n-1-j] & msk[8*j +: 8]) != pat[8*j +: 8]) hit = 1'b0;
          end
        end
      end
      if (hit) begin
        found    = 1'b1;
        found_at = start[OFFSET_BITS-1:0];
        r.status = ST_FIRST;
        r.offset = found_at;
      end else if (closing) begin
        r.status = ST_NO_MATCH;
      end
    end
    if (closing) clear_search();
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued bytes, drawing a random idle gap after each accepted
  // word when the sender is set to idle. A byte marked hold is not offered
  // until every result word due has arrived. The prediction for a word is
  // made at the edge where it is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      data_byte_i <= '0;
      last_byte_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        search_results_due.push_back(search_step(data_byte_i, last_byte_i));
        gap_left = sender_idle ? $urandom_range(0, 5) : 0;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (bytes_to_send.size() != 0 &&
                     !(bytes_to_send[0].hold && search_results_due.size() != 0)) begin
          next_word = bytes_to_send.pop_front();
          in_valid_i  <= 1'b1;
          data_byte_i <= next_word.data;
          last_byte_i <= next_word.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result words, checks each against the oldest prediction,
  // then holds ready low for a random stall when the receiver is set to idle.
  // A hold request keeps ready low for a long stretch so that the block backs
  // up and has to refuse input.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (search_results_due.size() == 0) begin
          flag_error($sformatf("result %0d with nothing due: status %0d offset %0d done %0d",
                               results_seen, status_o, match_offset_o, buffer_done_o));
        end else begin
          due = search_results_due.pop_front();
          if (status_o !== due.status || match_offset_o !== due.offset ||
              buffer_done_o !== due.done) begin
            flag_error($sformatf({"result %0d: expected status %0d offset %0d done %0d,",
                                  " got status %0d offset %0d done %0d"},
                                 results_seen, due.status, due.offset, due.done,
                                 status_o, match_offset_o, buffer_done_o));
          end
        end
        results_seen++;
        stall_left = receiver_idle ? $urandom_range(0, 5) : 0;
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // The byte queue is kept short so that the stimulus never runs far ahead.
  task automatic queue_byte(input logic [7:0] b, input logic l, input bit hold = 1'b0);
    while (bytes_to_send.size() >= 64) @(negedge clk_i);
    bytes_to_send.push_back('{data: b, last: l, hold: hold});
  endtask

  // Waits until nothing is queued, in flight or owed.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid_i || search_results_due.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_PATTERN_LOW:  pat_lo  = val;
      REG_PATTERN_HIGH: pat_hi  = val;
      REG_MASK_LOW:     mask_lo = val;
      REG_MASK_HIGH:    mask_hi = val;
      REG_PATTERN_LEN:  pat_len = val[LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Picks a random setting: lengths at the edges and beyond them now and then,
  // mask bytes that are often all clear or all set, and a pattern that mostly
  // respects its mask but is sometimes impossible to meet.
  task automatic random_setup();
    logic [127:0] m;
    logic [127:0] p;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 3))
        0:       m[8*i +: 8] = 8'h00;
        1:       m[8*i +: 8] = 8'hFF;
        default: m[8*i +: 8] = $urandom;
      endcase
      p[8*i +: 8] = $urandom;
    end
    if ($urandom_range(0, 7) != 0) p = p & m;
    case ($urandom_range(0, 7))
      0:       len = 0;
      1:       len = $urandom_range(17, 31);
      2:       len = MAX_PATTERN;
      default: len = $urandom_range(1, 15);
    endcase
    write_reg(REG_PATTERN_LOW,  p[63:0]);
    write_reg(REG_PATTERN_HIGH, p[127:64]);
    write_reg(REG_MASK_LOW,     m[63:0]);
    write_reg(REG_MASK_HIGH,    m[127:64]);
    write_reg(REG_PATTERN_LEN,  len);
  endtask

  // Queues one buffer of n bytes. When asked, a byte sequence that meets the
  // current pattern under its mask is planted at a random place, with random
  // values in the masked-off bits. One byte may be marked hold.
  task automatic queue_buffer(input int n, input bit plant, input int hold_at = -1);
    int           at;
    int           n_pat;
    logic [7:0]   b;
    logic [127:0] pat;
    logic [127:0] msk;
    n_pat = eff_len();
    pat   = {pat_hi, pat_lo};
    msk   = {mask_hi, mask_lo};
    at    = (plant && n >= n_pat) ? $urandom_range(0, n - n_pat) : -1;
    for (int j = 0; j < n; j++) begin
      b = $urandom;
      if (at >= 0 && j >= at && j < at + n_pat)
        b = (pat[8*(j-at) +: 8] & msk[8*(j-at) +: 8]) | (b & ~msk[8*(j-at) +: 8]);
      queue_byte(b, j == n - 1, j == hold_at);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int n;

    // Mirror the state the block holds after reset.
    pat_lo  = '0;
    pat_hi  = '0;
    mask_lo = '0;
    mask_hi = '0;
    pat_len = 1;
    clear_search();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the reset setting every byte matches, so the very first byte of a
    // buffer is reported as a match at offset zero.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // Every register written. A match that completes on the closing byte, and
    // a buffer too short to hold the pattern.
    write_reg(REG_PATTERN_LOW,  64'h0000_0000_EFBE_ADDE);
    write_reg(REG_PATTERN_HIGH, 64'h0);
    write_reg(REG_MASK_LOW,     64'h0000_0000_FFFF_FFFF);
    write_reg(REG_MASK_HIGH,    64'h0);
    write_reg(REG_PATTERN_LEN,  4);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b0);
    queue_byte(8'hBE, 1'b0);
    queue_byte(8'hEF, 1'b1);
    queue_byte(8'hDE, 1'b0);
    queue_byte(8'hAD, 1'b1);
    wait_idle();

    // A length of zero acts as one; the match is then reported again as an
    // earlier match on the bytes that follow.
    write_reg(REG_PATTERN_LOW, 64'hFF);
    write_reg(REG_MASK_LOW,    '1);
    write_reg(REG_PATTERN_LEN, 0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    wait_idle();

    // A pattern bit outside its mask can never be met.
    write_reg(REG_MASK_LOW,    64'h0F);
    write_reg(REG_PATTERN_LEN, 1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    wait_idle();

    // An over-long length is clipped to the full window of sixteen bytes.
    write_reg(REG_PATTERN_LOW,  '1);
    write_reg(REG_PATTERN_HIGH, '1);
    write_reg(REG_MASK_LOW,     '1);
    write_reg(REG_MASK_HIGH,    '1);
    write_reg(REG_PATTERN_LEN,  31);
    for (int i = 0; i < 16; i++) queue_byte(8'hFF, i == 15);
    wait_idle();

    // Back-pressure: the receiver stops for a long stretch while the sender
    // keeps offering, so the block fills and refuses input. Midway through a
    // buffer the sender then waits until every result word has come home.
    random_setup();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    hold_req      = 1'b1;
    for (int i = 0; i < 3; i++) queue_buffer(12, 1'b1);
    queue_buffer(20, 1'b1, 9);
    wait_idle();

    // Random phases, each with a fresh setting. Most buffers carry a planted
    // match; the rest are noise. One phase runs with no idling on either side.
    for (int phase = 0; phase < 8; phase++) begin
      random_setup();
      sender_idle   = (phase != 3);
      receiver_idle = (phase != 3);
      sent = 0;
      while (sent < 85) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
        queue_buffer(n, $urandom_range(0, 9) < 7, (phase == 5 && sent == 0) ? n / 2 : -1);
        sent += n;
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #25_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/mbps_pkg.sv
rtl/mbps_cell.sv
rtl/mbps_out_buf.sv
rtl/masked_byte_pattern_search_top.sv
tb/sv/masked_byte_pattern_search_top_test.sv
